// ===== hw/rtl/qfo_pkg.sv =====
// Shared types and constants for the quota FIFO outbox.
// Used by all modules but qfo_ram; depends on nothing else.
package qfo_pkg;

  // Fixed widths of the item, result and register data ports.
  localparam int HANDLE_W = 16;
  localparam int CNT_W    = 10;
  localparam int CTR_W    = 32;
  localparam int EIDX_W   = 4;
  localparam int DATA_W   = 32;

  // Flow count saturation value and capacity register reset value.
  localparam logic [CNT_W-1:0] CNT_MAX     = 10'd1023;
  localparam logic [CNT_W-1:0] CAP_DEFAULT = 10'd64;

  // Configuration register indexes (address bit 2).
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MODE     = 1'b1;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_POP  = 2'd1,
    OP_LOAD = 2'd2,
    OP_LINK = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_DIRECT  = 4'd0,
    ST_QUEUED  = 4'd1,
    ST_OFFDROP = 4'd2,
    ST_REFUSED = 4'd3,
    ST_ZEROQ   = 4'd4,
    ST_POPPED  = 4'd5,
    ST_EMPTY   = 4'd6,
    ST_LOADED  = 4'd7,
    ST_LINK    = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_HEADRD,
    S_HEAD,
    S_APPEND
  } state_t;

  // Commands to the flow table, at most one active per cycle.
  typedef struct packed {
    logic load;
    logic inc;
    logic dec;
  } flow_cmd_t;

  // Lookup result of the flow table.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] quota;
    logic [CNT_W-1:0] count;
  } flow_res_t;

endpackage

// ===== hw/rtl/qfo_ram.sv =====
// Queue store: simple dual-port synchronous memory, one write and one read per cycle.
// Read data is registered. No dependencies.
module qfo_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 49
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/qfo_flow.sv =====
// Per-flow quota table: key match lookup, count update and slot load.
// Depends on qfo_pkg for the command and lookup result types.
module qfo_flow #(
  parameter int FLOW_ENTRIES = 16,
  parameter int KEY_BITS     = 33,
  parameter int FIW          = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mode,
  input  logic [KEY_BITS-1:0]          lk_key,
  input  qfo_pkg::flow_cmd_t           cmd,
  input  logic [FIW-1:0]               ld_idx,
  input  logic [KEY_BITS-1:0]          ld_key,
  input  logic [qfo_pkg::CNT_W-1:0]    ld_quota,
  input  logic [qfo_pkg::CNT_W-1:0]    ld_count,
  input  logic                         ld_valid,
  output qfo_pkg::flow_res_t           res
);

  logic [FLOW_ENTRIES-1:0]   valid_r;
  logic [KEY_BITS-1:0]       key_r   [FLOW_ENTRIES];
  logic [qfo_pkg::CNT_W-1:0] quota_r [FLOW_ENTRIES];
  logic [qfo_pkg::CNT_W-1:0] count_r [FLOW_ENTRIES];
  logic [FIW-1:0]            hidx;
  logic                      hit;

  // Lowest valid slot whose key matches wins.
  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (mode && valid_r[i] && (key_r[i] == lk_key)) begin
        hit  = 1'b1;
        hidx = FIW'(i);
      end
    end
  end

  assign res.hit   = hit;
  assign res.quota = quota_r[hidx];
  assign res.count = count_r[hidx];

  // Slot load and count updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load) begin
      valid_r[ld_idx] <= ld_valid;
      key_r[ld_idx]   <= ld_key;
      quota_r[ld_idx] <= ld_quota;
      count_r[ld_idx] <= ld_count;
    end else if (cmd.dec && hit && (count_r[hidx] != '0)) begin
      count_r[hidx] <= count_r[hidx] - qfo_pkg::CNT_W'(1);
    end else if (cmd.inc && hit && (count_r[hidx] != qfo_pkg::CNT_MAX)) begin
      count_r[hidx] <= count_r[hidx] + qfo_pkg::CNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/quota_fifo_outbox.sv =====
// Link, load without backlog, drop and direct items: result from the decide state; pop
// reads the head entry first; a queued item may scan the store for its flow's oldest
// entry and close up the queue behind it, or evict the head (one store read per cycle).
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous, clears pointers, counters, flow table valid bits and control state;
// store contents are undefined and need no clearing pass. Results cannot be stalled.
module quota_fifo_outbox #(
  parameter int QUEUE_DEPTH  = 512,
  parameter int FLOW_ENTRIES = 16,
  parameter int KEY_BITS     = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [qfo_pkg::DATA_W-1:0]    pwdata,
  output logic [qfo_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [KEY_BITS-1:0]           in_flow_key,
  input  logic [qfo_pkg::HANDLE_W-1:0]  in_message_handle,
  input  logic                          in_connected,
  input  logic                          in_room_ok,
  input  logic [qfo_pkg::EIDX_W-1:0]    in_entry_index,
  input  logic [qfo_pkg::CNT_W-1:0]     in_entry_quota,
  input  logic                          in_entry_valid,
  output logic                          out_valid,
  output logic [3:0]                    out_status,
  output logic                          out_evicted,
  output logic [KEY_BITS-1:0]           out_evict_key,
  output logic [qfo_pkg::HANDLE_W-1:0]  out_out_handle,
  output logic [KEY_BITS-1:0]           out_out_key,
  output logic [qfo_pkg::CNT_W-1:0]     out_depth,
  output logic [qfo_pkg::CTR_W-1:0]     out_dropped_total,
  output logic [qfo_pkg::CTR_W-1:0]     out_dropped_outage,
  output logic [qfo_pkg::CTR_W-1:0]     out_refused_outage,
  output logic [qfo_pkg::CTR_W-1:0]     out_queued_total
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int FIW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int HW  = qfo_pkg::HANDLE_W;
  localparam int DW  = KEY_BITS + HW;
  localparam int NW  = qfo_pkg::CNT_W;
  localparam int TW  = qfo_pkg::CTR_W;

  // Physical store address of a logical queue position.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(p);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return AW'(s);
  endfunction

  qfo_pkg::state_t    state_r, state_nxt;
  qfo_pkg::op_t       op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [HW-1:0]      handle_r, handle_nxt;
  logic               conn_r, conn_nxt;
  logic               room_r, room_nxt;
  logic [qfo_pkg::EIDX_W-1:0] eidx_r, eidx_nxt;
  logic [NW-1:0]      equota_r, equota_nxt;
  logic               evalid_r, evalid_nxt;
  logic [AW-1:0]      head_r, head_nxt, head_inc;
  logic [CW-1:0]      qcount_r, qcount_nxt, last_pos;
  logic [TW-1:0]      drop_tot_r, drop_tot_nxt;
  logic [TW-1:0]      drop_out_r, drop_out_nxt;
  logic [TW-1:0]      refuse_out_r, refuse_out_nxt;
  logic [TW-1:0]      queued_tot_r, queued_tot_nxt;
  logic               link_up_r, link_up_nxt;
  logic [NW-1:0]      cap_r;
  logic               mode_r;
  logic [CW-1:0]      rd_pos_r, rd_pos_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [CW-1:0]      chk_pos_r, chk_pos_nxt;
  logic [NW-1:0]      n_r, n_nxt, n_inc, n_final;
  logic               out_valid_r, out_valid_nxt;
  qfo_pkg::status_t   status_r, status_nxt;
  logic               evicted_r, evicted_nxt;
  logic [KEY_BITS-1:0] ev_key_r, ev_key_nxt;
  logic [HW-1:0]      oh_r, oh_nxt;
  logic [KEY_BITS-1:0] ok_r, ok_nxt;
  logic               do_drop, do_refuse, q_full, cap_full, eidx_ok;

  logic               mem_wr_en, mem_rd_en;
  logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
  logic [DW-1:0]      mem_wr_data, mem_rd_data;
  logic [KEY_BITS-1:0] rd_key, lk_key;
  logic [HW-1:0]      rd_handle;
  qfo_pkg::flow_cmd_t fcmd;
  qfo_pkg::flow_res_t fl;

  assign rd_key    = mem_rd_data[DW-1:HW];
  assign rd_handle = mem_rd_data[HW-1:0];
  assign head_inc  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign last_pos  = qcount_r - CW'(1);
  assign q_full    = (qcount_r >= CW'(QUEUE_DEPTH));
  assign cap_full  = q_full || (TW'(qcount_r) >= TW'(cap_r));
  assign eidx_ok   = (TW'(eidx_r) < TW'(FLOW_ENTRIES));
  assign n_inc     = (chk_v_r && (rd_key == key_r) && (n_r != qfo_pkg::CNT_MAX))
                     ? n_r + NW'(1) : n_r;
  // The head's key is looked up when a head entry is removed.
  assign lk_key    = (state_r == qfo_pkg::S_HEAD) ? rd_key : key_r;

  qfo_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(DW)) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  qfo_flow #(.FLOW_ENTRIES(FLOW_ENTRIES), .KEY_BITS(KEY_BITS), .FIW(FIW)) u_flow (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .lk_key   (lk_key),
    .cmd      (fcmd),
    .ld_idx   (FIW'(eidx_r)),
    .ld_key   (key_r),
    .ld_quota (equota_r),
    .ld_count (n_final),
    .ld_valid (evalid_r),
    .res      (fl)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= qfo_pkg::CAP_DEFAULT;
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        qfo_pkg::REG_CAPACITY: cap_r  <= pwdata[NW-1:0];
        qfo_pkg::REG_MODE:     mode_r <= pwdata[0];
        default:               cap_r  <= cap_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      qfo_pkg::REG_CAPACITY: prdata = qfo_pkg::DATA_W'(cap_r);
      qfo_pkg::REG_MODE:     prdata = qfo_pkg::DATA_W'(mode_r);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sequencer: decides an item, then walks the store as needed.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    conn_nxt       = conn_r;
    room_nxt       = room_r;
    eidx_nxt       = eidx_r;
    equota_nxt     = equota_r;
    evalid_nxt     = evalid_r;
    head_nxt       = head_r;
    qcount_nxt     = qcount_r;
    queued_tot_nxt = queued_tot_r;
    link_up_nxt    = link_up_r;
    rd_pos_nxt     = rd_pos_r;
    chk_v_nxt      = chk_v_r;
    chk_pos_nxt    = chk_pos_r;
    n_nxt          = n_r;
    n_final        = n_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    evicted_nxt    = evicted_r;
    ev_key_nxt     = ev_key_r;
    oh_nxt         = oh_r;
    ok_nxt         = ok_r;
    do_drop        = 1'b0;
    do_refuse      = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = phys(head_r, rd_pos_r);
    mem_wr_en      = 1'b0;
    mem_wr_addr    = phys(head_r, qcount_r);
    mem_wr_data    = {key_r, handle_r};
    fcmd           = '0;
    drop_out_nxt   = drop_out_r;
    refuse_out_nxt = refuse_out_r;

    case (state_r)
      qfo_pkg::S_IDLE: begin
        if (start) begin
          op_nxt      = qfo_pkg::op_t'(in_op);
          key_nxt     = in_flow_key;
          handle_nxt  = in_message_handle;
          conn_nxt    = in_connected;
          room_nxt    = in_room_ok;
          eidx_nxt    = in_entry_index;
          equota_nxt  = in_entry_quota;
          evalid_nxt  = in_entry_valid;
          evicted_nxt = 1'b0;
          ev_key_nxt  = '0;
          oh_nxt      = '0;
          ok_nxt      = '0;
          state_nxt   = qfo_pkg::S_DECIDE;
        end
      end

      qfo_pkg::S_DECIDE: begin
        rd_pos_nxt = '0;
        chk_v_nxt  = 1'b0;
        n_nxt      = '0;
        case (op_r)
          qfo_pkg::OP_ENQ: begin
            if (conn_r && (qcount_r == '0)) begin
              oh_nxt        = handle_r;
              ok_nxt        = key_r;
              status_nxt    = qfo_pkg::ST_DIRECT;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end else if (cap_r == '0) begin
              do_drop       = 1'b1;
              status_nxt    = qfo_pkg::ST_OFFDROP;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end else if (!room_r) begin
              do_drop       = 1'b1;
              do_refuse     = 1'b1;
              status_nxt    = qfo_pkg::ST_REFUSED;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end else if (fl.hit && (fl.quota == '0)) begin
              do_drop       = 1'b1;
              status_nxt    = qfo_pkg::ST_ZEROQ;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end else if (fl.hit && (fl.count >= fl.quota) && (qcount_r != '0)) begin
              state_nxt = qfo_pkg::S_SCAN;
            end else if ((fl.hit && q_full) || (!fl.hit && cap_full)) begin
              state_nxt = qfo_pkg::S_HEADRD;
            end else begin
              state_nxt = qfo_pkg::S_APPEND;
            end
          end
          qfo_pkg::OP_POP: begin
            if (qcount_r == '0) begin
              status_nxt    = qfo_pkg::ST_EMPTY;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end else begin
              state_nxt = qfo_pkg::S_HEADRD;
            end
          end
          qfo_pkg::OP_LOAD: begin
            if (eidx_ok && (qcount_r != '0)) begin
              state_nxt = qfo_pkg::S_SCAN;
            end else begin
              // Empty queue loads with a zero count; a bad index loads nothing.
              n_final       = '0;
              fcmd.load     = eidx_ok;
              status_nxt    = qfo_pkg::ST_LOADED;
              out_valid_nxt = 1'b1;
              state_nxt     = qfo_pkg::S_IDLE;
            end
          end
          default: begin
            if (link_up_r && !conn_r) begin
              drop_out_nxt   = '0;
              refuse_out_nxt = '0;
            end
            link_up_nxt   = conn_r;
            status_nxt    = qfo_pkg::ST_LINK;
            out_valid_nxt = 1'b1;
            state_nxt     = qfo_pkg::S_IDLE;
          end
        endcase
      end

      qfo_pkg::S_SCAN: begin
        // One read issued per cycle, compared in the following cycle.
        if (rd_pos_r < qcount_r) begin
          mem_rd_en   = 1'b1;
          rd_pos_nxt  = rd_pos_r + CW'(1);
          chk_v_nxt   = 1'b1;
          chk_pos_nxt = rd_pos_r;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (op_r == qfo_pkg::OP_LOAD) begin
          n_nxt = n_inc;
          if (chk_v_r && (chk_pos_r == last_pos)) begin
            n_final       = n_inc;
            fcmd.load     = 1'b1;
            chk_v_nxt     = 1'b0;
            status_nxt    = qfo_pkg::ST_LOADED;
            out_valid_nxt = 1'b1;
            state_nxt     = qfo_pkg::S_IDLE;
          end
        end else if (chk_v_r && (rd_key == key_r)) begin
          chk_v_nxt = 1'b0;
          if ((chk_pos_r == '0) || (chk_pos_r == last_pos)) begin
            // Oldest own entry at either end: no close-up needed.
            if (chk_pos_r == '0) begin
              head_nxt = head_inc;
            end
            fcmd.dec    = 1'b1;
            qcount_nxt  = qcount_r - CW'(1);
            do_drop     = 1'b1;
            evicted_nxt = 1'b1;
            ev_key_nxt  = key_r;
            state_nxt   = qfo_pkg::S_APPEND;
          end else begin
            rd_pos_nxt = chk_pos_r + CW'(1);
            state_nxt  = qfo_pkg::S_SHIFT;
          end
        end else if (chk_v_r && (chk_pos_r == last_pos)) begin
          // No own entry queued.
          chk_v_nxt = 1'b0;
          state_nxt = q_full ? qfo_pkg::S_HEADRD : qfo_pkg::S_APPEND;
        end
      end

      qfo_pkg::S_SHIFT: begin
        // Move each later entry one place toward the head.
        if (rd_pos_r < qcount_r) begin
          mem_rd_en   = 1'b1;
          rd_pos_nxt  = rd_pos_r + CW'(1);
          chk_v_nxt   = 1'b1;
          chk_pos_nxt = rd_pos_r;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = phys(head_r, chk_pos_r - CW'(1));
          mem_wr_data = mem_rd_data;
          if (chk_pos_r == last_pos) begin
            chk_v_nxt   = 1'b0;
            fcmd.dec    = 1'b1;
            qcount_nxt  = qcount_r - CW'(1);
            do_drop     = 1'b1;
            evicted_nxt = 1'b1;
            ev_key_nxt  = key_r;
            state_nxt   = qfo_pkg::S_APPEND;
          end
        end
      end

      qfo_pkg::S_HEADRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = head_r;
        state_nxt   = qfo_pkg::S_HEAD;
      end

      qfo_pkg::S_HEAD: begin
        // Remove the head; its own flow releases quota.
        fcmd.dec   = 1'b1;
        head_nxt   = head_inc;
        qcount_nxt = qcount_r - CW'(1);
        if (op_r == qfo_pkg::OP_POP) begin
          oh_nxt        = rd_handle;
          ok_nxt        = rd_key;
          status_nxt    = qfo_pkg::ST_POPPED;
          out_valid_nxt = 1'b1;
          state_nxt     = qfo_pkg::S_IDLE;
        end else begin
          do_drop     = 1'b1;
          evicted_nxt = 1'b1;
          ev_key_nxt  = rd_key;
          state_nxt   = qfo_pkg::S_APPEND;
        end
      end

      qfo_pkg::S_APPEND: begin
        mem_wr_en      = 1'b1;
        qcount_nxt     = qcount_r + CW'(1);
        queued_tot_nxt = queued_tot_r + TW'(1);
        fcmd.inc       = 1'b1;
        status_nxt     = qfo_pkg::ST_QUEUED;
        out_valid_nxt  = 1'b1;
        state_nxt      = qfo_pkg::S_IDLE;
      end

      default: begin
        state_nxt = qfo_pkg::S_IDLE;
      end
    endcase

    // Drop counters.
    drop_tot_nxt = drop_tot_r + TW'(do_drop);
    if (do_drop) begin
      drop_out_nxt = drop_out_r + TW'(1);
    end
    if (do_refuse) begin
      refuse_out_nxt = refuse_out_r + TW'(1);
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qfo_pkg::S_IDLE;
      head_r       <= '0;
      qcount_r     <= '0;
      drop_tot_r   <= '0;
      drop_out_r   <= '0;
      refuse_out_r <= '0;
      queued_tot_r <= '0;
      link_up_r    <= 1'b0;
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      qcount_r     <= qcount_nxt;
      drop_tot_r   <= drop_tot_nxt;
      drop_out_r   <= drop_out_nxt;
      refuse_out_r <= refuse_out_nxt;
      queued_tot_r <= queued_tot_nxt;
      link_up_r    <= link_up_nxt;
      chk_v_r      <= chk_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    handle_r  <= handle_nxt;
    conn_r    <= conn_nxt;
    room_r    <= room_nxt;
    eidx_r    <= eidx_nxt;
    equota_r  <= equota_nxt;
    evalid_r  <= evalid_nxt;
    rd_pos_r  <= rd_pos_nxt;
    chk_pos_r <= chk_pos_nxt;
    n_r       <= n_nxt;
    status_r  <= status_nxt;
    evicted_r <= evicted_nxt;
    ev_key_r  <= ev_key_nxt;
    oh_r      <= oh_nxt;
    ok_r      <= ok_nxt;
  end

  assign busy               = (state_r != qfo_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_evicted        = evicted_r;
  assign out_evict_key      = ev_key_r;
  assign out_out_handle     = oh_r;
  assign out_out_key        = ok_r;
  assign out_depth          = NW'(qcount_r);
  assign out_dropped_total  = drop_tot_r;
  assign out_dropped_outage = drop_out_r;
  assign out_refused_outage = refuse_out_r;
  assign out_queued_total   = queued_tot_r;

endmodule

// ===== hw/rtl/qfo_checker.sv =====
// Port-level assertions for the quota FIFO outbox, bound to the top level.
// Depends on qfo_pkg for the status codes.
module qfo_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_status,
  input logic       out_evicted,
  input logic [9:0] out_depth
);

  // An accepted item raises busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Two results never follow in consecutive cycles.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // A direct pass or an empty pop leaves the queue empty.
  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == qfo_pkg::ST_DIRECT) ||
                   (out_status == qfo_pkg::ST_EMPTY))) |-> (out_depth == '0))
    else $error("nonzero depth on direct or empty result");

  // Only a queued item can evict an older entry.
  a_evict_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_status == qfo_pkg::ST_QUEUED))
    else $error("eviction reported without queuing");

endmodule

bind quota_fifo_outbox qfo_checker u_qfo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_evicted(out_evicted),
  .out_depth  (out_depth)
);

// ===== bench/quota_fifo_outbox_tb.sv =====
// Self-checking testbench for the quota FIFO outbox: directed and random items
// are checked against an in-bench predictor of the queue. Depends on qfo_pkg
// and on the quota_fifo_outbox RTL.
module quota_fifo_outbox_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = 512;
  localparam int FLOWS   = 16;
  localparam int KB      = 33;
  localparam int LIMIT   = 2000000;

  typedef struct {
    qfo_pkg::op_t    op;
    logic [KB-1:0]   key;
    logic [15:0]     handle;
    logic            connected;
    logic            room_ok;
    logic [3:0]      eidx;
    logic [9:0]      equota;
    logic            evalid;
  } outbox_item_t;

  typedef struct {
    qfo_pkg::status_t status;
    logic            evicted;
    logic [KB-1:0]   ev_key;
    logic [15:0]     o_handle;
    logic [KB-1:0]   o_key;
    logic [9:0]      depth;
    logic [31:0]     drop_tot;
    logic [31:0]     drop_out;
    logic [31:0]     ref_out;
    logic [31:0]     q_tot;
  } outbox_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [KB-1:0] in_flow_key = '0;
  logic [15:0] in_message_handle = '0;
  logic in_connected = 1'b0, in_room_ok = 1'b0, in_entry_valid = 1'b0;
  logic [3:0] in_entry_index = '0;
  logic [9:0] in_entry_quota = '0;
  logic out_valid, out_evicted;
  logic [3:0] out_status;
  logic [KB-1:0] out_evict_key, out_out_key;
  logic [15:0] out_out_handle;
  logic [9:0] out_depth;
  logic [31:0] out_dropped_total, out_dropped_outage, out_refused_outage, out_queued_total;

  quota_fifo_outbox dut (.*);

  always #5 clk = ~clk;

  // Stimulus waiting to be sent and results waiting to come back.
  outbox_item_t   pending_items[$];
  outbox_result_t expected_results[$];
  outbox_item_t   cur_item;
  int             idle_pct = 0;
  bit             failed = 0;
  int             cycles = 0;

  // Shadow state of the outbox.
  logic [KB-1:0] sh_key[DEPTH];
  logic [15:0]   sh_handle[DEPTH];
  int            sh_head, sh_count;
  logic [KB-1:0] fl_key[FLOWS];
  int            fl_quota[FLOWS], fl_count[FLOWS];
  bit            fl_valid[FLOWS];
  logic [31:0]   n_drop_tot, n_drop_out, n_ref_out, n_q_tot;
  bit            link_up_seen;
  int            cfg_capacity = 64;
  bit            cfg_flow_mode = 0;

  logic [KB-1:0] key_pool[4];

  // Append one item to the stimulus queue.
  function automatic void add_item(outbox_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic int slot_of(int pos);
    return (sh_head + pos) % DEPTH;
  endfunction

  function automatic int lookup_flow(logic [KB-1:0] k);
    if (!cfg_flow_mode) return -1;
    for (int i = 0; i < FLOWS; i++)
      if (fl_valid[i] && fl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void count_drop(bit refused);
    n_drop_tot++;
    n_drop_out++;
    if (refused) n_ref_out++;
  endfunction

  // Remove one entry, give back its flow quota and close up the gap.
  function automatic void remove_entry(int pos);
    int f;
    f = lookup_flow(sh_key[slot_of(pos)]);
    if (f >= 0 && fl_count[f] > 0) fl_count[f]--;
    if (pos == 0) begin
      sh_head = (sh_head + 1) % DEPTH;
    end else begin
      for (int i = pos; i + 1 < sh_count; i++) begin
        sh_key[slot_of(i)] = sh_key[slot_of(i + 1)];
        sh_handle[slot_of(i)] = sh_handle[slot_of(i + 1)];
      end
    end
    sh_count--;
  endfunction

  // Work out the result of one accepted item and queue it.
  function automatic void predict_outbox(outbox_item_t it);
    outbox_result_t r;
    int cap, f, n;
    r = '{qfo_pkg::ST_DIRECT, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0};
    cap = cfg_capacity > DEPTH ? DEPTH : cfg_capacity;
    case (it.op)
      qfo_pkg::OP_ENQ: begin
        if (it.connected && sh_count == 0) begin
          r.status = qfo_pkg::ST_DIRECT;
          r.o_handle = it.handle;
          r.o_key = it.key;
        end else if (cap == 0) begin
          r.status = qfo_pkg::ST_OFFDROP;
          count_drop(0);
        end else if (!it.room_ok) begin
          r.status = qfo_pkg::ST_REFUSED;
          count_drop(1);
        end else begin
          f = lookup_flow(it.key);
          if (f >= 0 && fl_quota[f] == 0) begin
            r.status = qfo_pkg::ST_ZEROQ;
            count_drop(0);
          end else begin
            if (f >= 0) begin
              // A flow at its quota gives up its own oldest entry.
              if (fl_count[f] >= fl_quota[f]) begin
                for (int i = 0; i < sh_count; i++) begin
                  if (sh_key[slot_of(i)] == it.key) begin
                    remove_entry(i);
                    count_drop(0);
                    r.evicted = 1'b1;
                    r.ev_key = it.key;
                    break;
                  end
                end
              end
              if (!r.evicted && sh_count >= DEPTH) begin
                r.ev_key = sh_key[slot_of(0)];
                remove_entry(0);
                count_drop(0);
                r.evicted = 1'b1;
              end
            end else if (sh_count >= cap) begin
              r.ev_key = sh_key[slot_of(0)];
              remove_entry(0);
              count_drop(0);
              r.evicted = 1'b1;
            end
            sh_key[slot_of(sh_count)] = it.key;
            sh_handle[slot_of(sh_count)] = it.handle;
            sh_count++;
            n_q_tot++;
            f = lookup_flow(it.key);
            if (f >= 0 && fl_count[f] < 1023) fl_count[f]++;
            r.status = qfo_pkg::ST_QUEUED;
          end
        end
      end
      qfo_pkg::OP_POP: begin
        if (sh_count == 0) begin
          r.status = qfo_pkg::ST_EMPTY;
        end else begin
          r.o_key = sh_key[slot_of(0)];
          r.o_handle = sh_handle[slot_of(0)];
          remove_entry(0);
          r.status = qfo_pkg::ST_POPPED;
        end
      end
      qfo_pkg::OP_LOAD: begin
        n = 0;
        for (int i = 0; i < sh_count; i++)
          if (sh_key[slot_of(i)] == it.key && n < 1023) n++;
        fl_key[it.eidx] = it.key;
        fl_quota[it.eidx] = it.equota;
        fl_count[it.eidx] = n;
        fl_valid[it.eidx] = it.evalid;
        r.status = qfo_pkg::ST_LOADED;
      end
      default: begin
        // Losing the link starts a new outage.
        if (link_up_seen && !it.connected) begin
          n_drop_out = '0;
          n_ref_out = '0;
        end
        link_up_seen = it.connected;
        r.status = qfo_pkg::ST_LINK;
      end
    endcase
    r.depth = sh_count[9:0];
    r.drop_tot = n_drop_tot;
    r.drop_out = n_drop_out;
    r.ref_out = n_ref_out;
    r.q_tot = n_q_tot;
    expected_results = {expected_results, r};
  endfunction

  // Driver: presents the next pending item, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_outbox(cur_item);
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending_items[0];
          pending_items.delete(0);
          start <= 1'b1;
          in_op <= cur_item.op;
          in_flow_key <= cur_item.key;
          in_message_handle <= cur_item.handle;
          in_connected <= cur_item.connected;
          in_room_ok <= cur_item.room_ok;
          in_entry_index <= cur_item.eidx;
          in_entry_quota <= cur_item.equota;
          in_entry_valid <= cur_item.evalid;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1;
    end
  endfunction

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    outbox_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding, status %0d", out_status);
        failed = 1;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        check_field("status", e.status, out_status);
        check_field("evicted", e.evicted, out_evicted);
        check_field("evict_key", e.ev_key, out_evict_key);
        check_field("out_handle", e.o_handle, out_out_handle);
        check_field("out_key", e.o_key, out_out_key);
        check_field("depth", e.depth, out_depth);
        check_field("dropped_total", e.drop_tot, out_dropped_total);
        check_field("dropped_outage", e.drop_out, out_dropped_outage);
        check_field("refused_outage", e.ref_out, out_refused_outage);
        check_field("queued_total", e.q_tot, out_queued_total);
      end
    end
  end

  // Watchdog, sized from the slowest legal run with ample margin.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("quota_fifo_outbox test failed");
      $finish;
    end
  end

  function automatic outbox_item_t mk(qfo_pkg::op_t op, logic [KB-1:0] k, logic [15:0] h,
                                      logic conn, logic room, logic [3:0] ei,
                                      logic [9:0] eq, logic ev);
    outbox_item_t it;
    it = '{op, k, h, conn, room, ei, eq, ev};
    return it;
  endfunction

  // Random item, weighted toward enqueues and pops so the queue fills and drains.
  function automatic outbox_item_t rand_item(int enq_w, int pop_w, int up_pct);
    outbox_item_t it;
    int roll;
    roll = $urandom_range(99);
    it.op = roll < enq_w ? qfo_pkg::OP_ENQ :
            roll < enq_w + pop_w ? qfo_pkg::OP_POP :
            roll < enq_w + pop_w + 6 ? qfo_pkg::OP_LOAD : qfo_pkg::OP_LINK;
    it.key = $urandom_range(99) < 15 ? {1'($urandom), 32'($urandom)}
                                     : key_pool[$urandom_range(3)];
    it.handle = 16'($urandom);
    it.connected = $urandom_range(99) < up_pct;
    it.room_ok = $urandom_range(99) < 90;
    it.eidx = 4'($urandom);
    case ($urandom_range(3))
      0: it.equota = 10'($urandom_range(512));
      1: it.equota = 10'd512;
      default: it.equota = 10'($urandom_range(4));
    endcase
    it.evalid = $urandom_range(99) < 80;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write in setup and access phases; shadow copy follows at the access edge.
  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == qfo_pkg::REG_CAPACITY) cfg_capacity = value[9:0];
    else cfg_flow_mode = value[0];
  endtask

  task automatic random_run(int n, int enq_w, int pop_w, int up_pct);
    repeat (n) add_item(rand_item(enq_w, pop_w, up_pct));
    wait_idle();
  endtask

  initial begin
    logic [KB-1:0] ka, kb, kc, ke;
    sh_head = 0; sh_count = 0;
    n_drop_tot = '0; n_drop_out = '0; n_ref_out = '0; n_q_tot = '0;
    link_up_seen = 0;
    for (int i = 0; i < FLOWS; i++) begin
      fl_valid[i] = 0; fl_key[i] = '0; fl_quota[i] = 0; fl_count[i] = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {1'b1, 32'($urandom)};
    key_pool[3] = {1'b0, 32'($urandom)};
    ka = key_pool[0]; kb = key_pool[1]; kc = key_pool[2]; ke = key_pool[3];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: direct pass, queueing behind a backlog, refusal, pops, outage clear, load.
    add_item(mk(qfo_pkg::OP_LINK, ka, 0, 1, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kb, 16'hFFFF, 1, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, ka, 16'h0000, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kc, 16'h1234, 1, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kc, 16'h5555, 0, 0, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_POP, ka, 0, 0, 0, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_POP, ka, 0, 1, 0, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_POP, ka, 0, 1, 0, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_LINK, ka, 0, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_LOAD, ka, 0, 0, 1, 4'd15, 10'd512, 1));
    wait_idle();

    // Directed with flow quotas: zero quota, own-oldest eviction from mid-queue.
    write_reg(qfo_pkg::REG_MODE, 32'd1);
    add_item(mk(qfo_pkg::OP_LOAD, ka, 0, 0, 1, 0, 10'd0, 1));
    add_item(mk(qfo_pkg::OP_LOAD, kb, 0, 0, 1, 1, 10'd1, 1));
    add_item(mk(qfo_pkg::OP_ENQ, ka, 16'h0001, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kc, 16'h0002, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kb, 16'h0003, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kc, 16'h0004, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_ENQ, kb, 16'h0005, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_LOAD, ke, 0, 0, 1, 2, 10'd1, 1));
    add_item(mk(qfo_pkg::OP_ENQ, ke, 16'h0006, 0, 1, 0, 0, 0));
    wait_idle();
    // Pops with the table off keep the count, so the flow is at quota with nothing queued.
    write_reg(qfo_pkg::REG_MODE, 32'd0);
    repeat (6) add_item(mk(qfo_pkg::OP_POP, ka, 0, 0, 0, 0, 0, 0));
    wait_idle();
    write_reg(qfo_pkg::REG_MODE, 32'd1);
    add_item(mk(qfo_pkg::OP_ENQ, ke, 16'h0007, 0, 1, 0, 0, 0));
    add_item(mk(qfo_pkg::OP_POP, ka, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Random phases over several settings.
    idle_pct = 11;
    write_reg(qfo_pkg::REG_CAPACITY, 32'd3);
    random_run(14, 60, 20, 30);
    write_reg(qfo_pkg::REG_CAPACITY, 32'd0);
    random_run(6, 60, 20, 30);
    idle_pct = 59;
    write_reg(qfo_pkg::REG_MODE, 32'd0);
    write_reg(qfo_pkg::REG_CAPACITY, 32'd1023);
    random_run(14, 55, 30, 20);
    idle_pct = 0;
    write_reg(qfo_pkg::REG_MODE, 32'd1);
    write_reg(qfo_pkg::REG_CAPACITY, 32'd1);
    random_run(10, 60, 20, 30);
    write_reg(qfo_pkg::REG_CAPACITY, 32'd512);
    random_run(14, 60, 25, 25);

    // Fill the whole store under large quotas so the head must give way.
    write_reg(qfo_pkg::REG_CAPACITY, 32'd1023);
    add_item(mk(qfo_pkg::OP_LOAD, kc, 0, 0, 1, 0, 10'd512, 1));
    add_item(mk(qfo_pkg::OP_LOAD, ke, 0, 0, 1, 1, 10'd512, 1));
    for (int i = 0; i < 514; i++)
      add_item(mk(qfo_pkg::OP_ENQ, i[0] ? kc : ke, 16'($urandom), 0, 1, 0, 0, 0));
    random_run(6, 40, 50, 30);

    if (!failed) begin
      $display("quota_fifo_outbox test passed");
    end else begin
      $display("quota_fifo_outbox test failed");
    end
    $finish;
  end

endmodule
